>>> rtl/wes_pkg.sv
// shared constants, types and codes of the wave equation stencil step
package wes_pkg;

  // fixed point format of heights and velocities
  localparam int FRAC_BITS = 12;
  localparam int Q16       = 16;
  localparam int ROUND_HALF = 1 << (Q16 - 1);

  // field widths
  localparam int H_W  = 13;
  localparam int V_W  = 15;
  localparam int CC_W = 24;
  localparam int DF_W = 17;
  localparam int DT_W = 16;

  // saturation limits of interior cells
  localparam int VEL_LIM = 2 << FRAC_BITS;
  localparam int HGT_LIM = 1 << (FRAC_BITS - 1);

  // datapath widths
  localparam int LAP_W = H_W + 4;
  localparam int P1_W  = LAP_W + CC_W + 1;
  localparam int V1_W  = P1_W - Q16 + 1;
  localparam int P2_W  = V1_W + DF_W + 1;
  localparam int P3_W  = V_W + DT_W + 1;
  localparam int HS_W  = P3_W - Q16 + 1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUPLING  = 2'd0,
    REG_DAMPING   = 2'd1,
    REG_TIME_STEP = 2'd2
  } cfg_reg_e;

  localparam logic [CC_W-1:0] CC_RESET = CC_W'(104858);
  localparam logic [DF_W-1:0] DF_RESET = DF_W'(64225);
  localparam logic [DT_W-1:0] DT_RESET = DT_W'(1049);

  // column window
  localparam int COLS_W = 2;
  localparam logic [COLS_W-1:0] COLS_NONE = COLS_W'(0);
  localparam logic [COLS_W-1:0] COLS_FULL = COLS_W'(2);

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CC_W-1:0] cc;
    logic [DF_W-1:0] df;
    logic [DT_W-1:0] dt;
  } cfg_t;

  // one classified item: up to two results
  typedef struct packed {
    logic                  has_first;
    logic                  compute;
    logic                  has_second;
    logic signed [H_W-1:0] older;
    logic signed [H_W-1:0] right;
    logic signed [H_W-1:0] above;
    logic signed [H_W-1:0] below;
    logic signed [H_W-1:0] center;
    logic signed [V_W-1:0] hvel;
    logic signed [V_W-1:0] vel;
  } job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

>>> rtl/wes_if.sv
// channel interfaces of the wave equation stencil step
interface wes_in_if;
  import wes_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [H_W-1:0] height_above;
  logic signed [H_W-1:0] height_here;
  logic signed [H_W-1:0] height_below;
  logic signed [V_W-1:0] velocity_here;
  logic                  row_start;
  logic                  row_end;
  logic                  edge_row;

  modport source (output valid, height_above, height_here, height_below, velocity_here,
                  row_start, row_end, edge_row, input ready);
  modport sink (input valid, height_above, height_here, height_below, velocity_here,
                row_start, row_end, edge_row, output ready);
endinterface

interface wes_out_if;
  import wes_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [H_W-1:0] new_height;
  logic signed [V_W-1:0] new_velocity;
  logic                  last_of_run;

  modport source (output valid, new_height, new_velocity, last_of_run, input ready);
  modport sink (input valid, new_height, new_velocity, last_of_run, output ready);
endinterface

interface wes_cfg_if;
  import wes_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

>>> rtl/wes_queue.sv
// short job queue between the front and the back
module wes_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wes_pkg::job_t   push_job_i,
  input  logic            pop_i,
  output wes_pkg::job_t   head_job_o,
  output wes_pkg::q_stat_t stat_o
);
  import wes_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  assign head_job_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

endmodule

>>> rtl/wes_front.sv
// front end: takes items, keeps the column window and classifies each item
module wes_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  wes_in_if.sink           in_i,
  input  wes_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output wes_pkg::job_t    job_o
);
  import wes_pkg::*;

  logic signed [H_W-1:0] older_q, above_q, center_q, below_q;
  logic signed [V_W-1:0] hvel_q;
  logic [COLS_W-1:0]     cols_q, cols_d;
  logic [COLS_W-1:0]     cols_eff;
  logic                  accept;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  // a row start drops whatever column was held
  assign cols_eff = in_i.row_start ? COLS_NONE : cols_q;

  always_comb begin
    job_o.has_first  = (cols_eff != COLS_NONE);
    job_o.compute    = (cols_eff == COLS_FULL) && !in_i.edge_row;
    job_o.has_second = in_i.row_end;
    job_o.older      = older_q;
    job_o.right      = in_i.height_here;
    job_o.above      = above_q;
    job_o.below      = below_q;
    job_o.center     = center_q;
    job_o.hvel       = hvel_q;
    job_o.vel        = in_i.velocity_here;
  end

  assign push_o = accept && (job_o.has_first || job_o.has_second);

  always_comb begin
    cols_d = cols_q;
    if (accept) begin
      if (in_i.row_end) begin
        cols_d = COLS_NONE;
      end else if (cols_eff != COLS_FULL) begin
        cols_d = cols_eff + 1'b1;
      end else begin
        cols_d = cols_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q   <= COLS_NONE;
      older_q  <= '0;
      above_q  <= '0;
      center_q <= '0;
      below_q  <= '0;
      hvel_q   <= '0;
    end else begin
      cols_q <= cols_d;
      if (accept) begin
        older_q  <= center_q;
        above_q  <= in_i.height_above;
        center_q <= in_i.height_here;
        below_q  <= in_i.height_below;
        hvel_q   <= in_i.velocity_here;
      end
    end
  end

endmodule

>>> rtl/wes_back.sv
// back end: stencil arithmetic sequencer and result register
module wes_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wes_pkg::cfg_t    cfg_i,
  input  wes_pkg::q_stat_t q_stat_i,
  input  wes_pkg::job_t    head_job_i,
  output logic             pop_o,
  wes_out_if.source        out_o
);
  import wes_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE       = 7'b0000001,
    ST_LAP        = 7'b0000010,
    ST_DAMP       = 7'b0000100,
    ST_STEP       = 7'b0001000,
    ST_FIN        = 7'b0010000,
    ST_OUT_FIRST  = 7'b0100000,
    ST_OUT_SECOND = 7'b1000000
  } back_state_e;

  back_state_e state_q, state_d;
  job_t        job_q, job_d;

  logic signed [LAP_W-1:0] lap_q, lap_d, lap_head;
  logic signed [P1_W-1:0]  prod1_q, prod1_d, p1r;
  logic signed [P2_W-1:0]  prod2_q, prod2_d, p2r;
  logic signed [P3_W-1:0]  prod3_q, prod3_d, p3r;
  logic signed [V1_W-1:0]  v1;
  logic signed [V_W-1:0]   vc;
  logic signed [HS_W-1:0]  hs;
  logic signed [H_W-1:0]   hc;
  logic signed [H_W-1:0]   res_h_q, res_h_d;
  logic signed [V_W-1:0]   res_v_q, res_v_d;
  logic signed [CC_W:0]    cc_s;
  logic signed [DF_W:0]    df_s;
  logic signed [DT_W:0]    dt_s;

  assign cc_s = $signed({1'b0, cfg_i.cc});
  assign df_s = $signed({1'b0, cfg_i.df});
  assign dt_s = $signed({1'b0, cfg_i.dt});

  // five-point laplacian of the head job
  assign lap_head = LAP_W'(head_job_i.older) + LAP_W'(head_job_i.right)
                  + LAP_W'(head_job_i.above) + LAP_W'(head_job_i.below)
                  - (LAP_W'(head_job_i.center) <<< 2);

  // round to nearest, ties up, then saturate
  always_comb begin
    p1r = (prod1_q + P1_W'(ROUND_HALF)) >>> Q16;
    v1  = V1_W'(job_q.hvel) + V1_W'(p1r);
    p2r = (prod2_q + P2_W'(ROUND_HALF)) >>> Q16;
    if (p2r > P2_W'(VEL_LIM)) begin
      vc = V_W'(VEL_LIM);
    end else if (p2r < -P2_W'(VEL_LIM)) begin
      vc = -V_W'(VEL_LIM);
    end else begin
      vc = V_W'(p2r);
    end
    p3r = (prod3_q + P3_W'(ROUND_HALF)) >>> Q16;
    hs  = HS_W'(job_q.center) + HS_W'(p3r);
    if (hs > HS_W'(HGT_LIM)) begin
      hc = H_W'(HGT_LIM);
    end else if (hs < -HS_W'(HGT_LIM)) begin
      hc = -H_W'(HGT_LIM);
    end else begin
      hc = H_W'(hs);
    end
  end

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    lap_d   = lap_q;
    prod1_d = prod1_q;
    prod2_d = prod2_q;
    prod3_d = prod3_q;
    res_h_d = res_h_q;
    res_v_d = res_v_q;
    pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          job_d = head_job_i;
          lap_d = lap_head;
          if (head_job_i.has_first && head_job_i.compute) begin
            state_d = ST_LAP;
          end else if (head_job_i.has_first) begin
            res_h_d = head_job_i.center;
            res_v_d = head_job_i.hvel;
            state_d = ST_OUT_FIRST;
          end else begin
            res_h_d = head_job_i.right;
            res_v_d = head_job_i.vel;
            state_d = ST_OUT_SECOND;
          end
        end
      end
      ST_LAP: begin
        prod1_d = P1_W'(lap_q) * P1_W'(cc_s);
        state_d = ST_DAMP;
      end
      ST_DAMP: begin
        prod2_d = P2_W'(v1) * P2_W'(df_s);
        state_d = ST_STEP;
      end
      ST_STEP: begin
        res_v_d = vc;
        prod3_d = P3_W'(vc) * P3_W'(dt_s);
        state_d = ST_FIN;
      end
      ST_FIN: begin
        res_h_d = hc;
        state_d = ST_OUT_FIRST;
      end
      ST_OUT_FIRST: begin
        if (out_o.ready) begin
          if (job_q.has_second) begin
            res_h_d = job_q.right;
            res_v_d = job_q.vel;
            state_d = ST_OUT_SECOND;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_OUT_SECOND: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    lap_q   <= lap_d;
    prod1_q <= prod1_d;
    prod2_q <= prod2_d;
    prod3_q <= prod3_d;
    res_h_q <= res_h_d;
    res_v_q <= res_v_d;
  end

  assign out_o.valid        = (state_q == ST_OUT_FIRST) || (state_q == ST_OUT_SECOND);
  assign out_o.new_height   = res_h_q;
  assign out_o.new_velocity = res_v_q;
  assign out_o.last_of_run  = (state_q == ST_OUT_SECOND) || !job_q.has_second;

endmodule

>>> rtl/wave_equation_stencil_step.sv
// top level of the damped 2d wave equation stencil step
// order: items go through the queue to the back sequencer; a pass-through result is
//   shown in ST_OUT_FIRST straight after ST_IDLE, an interior cell after ST_LAP, ST_DAMP,
//   ST_STEP and ST_FIN (lap, damping and time-step multiplies in turn); the row-end cell
//   follows in ST_OUT_SECOND once the first is taken; output back pressure holds both
// reset: async active low; clears window, column count, queue and sequencer,
//   loads the default coupling, damping and time step registers
module wave_equation_stencil_step (
  input  logic       clk_i,
  input  logic       rst_ni,
  wes_in_if.sink     in_i,
  wes_out_if.source  out_o,
  wes_cfg_if.sink    cfg_i
);
  import wes_pkg::*;

  cfg_t    cfg_q;
  q_stat_t q_stat;
  job_t    push_job;
  job_t    head_job;
  logic    q_push;
  logic    q_pop;

  // configuration registers, always ready; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cc <= CC_RESET;
      cfg_q.df <= DF_RESET;
      cfg_q.dt <= DT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.reg_index))
        REG_COUPLING:  cfg_q.cc <= cfg_i.wdata[CC_W-1:0];
        REG_DAMPING:   cfg_q.df <= cfg_i.wdata[DF_W-1:0];
        REG_TIME_STEP: cfg_q.dt <= cfg_i.wdata[DT_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // front: column window and classification of each item
  wes_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (q_push),
    .job_o    (push_job)
  );

  // decouples item intake from the multi-cycle arithmetic
  wes_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .pop_i      (q_pop),
    .head_job_o (head_job),
    .stat_o     (q_stat)
  );

  // back: laplacian, velocity and height update, result register
  wes_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_stat_i   (q_stat),
    .head_job_i (head_job),
    .pop_o      (q_pop),
    .out_o      (out_o)
  );

`ifndef SYNTHESIS
  // never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("job popped from empty queue");

  // never push into a full queue
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("job pushed into full queue");

  // queue fill never exceeds its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  // the row-end cell follows the delayed cell at once
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last_of_run |=> out_o.valid)
    else $error("second result of an item missing");
`endif

endmodule

>>> tb/tb_wave_equation_stencil_step.sv
// testbench of the wave equation stencil step: streamed columns against a local predictor
`timescale 1ns / 1ps

module tb_wave_equation_stencil_step;
  import wes_pkg::*;

  // one column triple as it goes into the block
  typedef struct {
    logic signed [H_W-1:0] above;
    logic signed [H_W-1:0] here;
    logic signed [H_W-1:0] below;
    logic signed [V_W-1:0] vel;
    logic                  row_start;
    logic                  row_end;
    logic                  edge_row;
  } column_t;

  // one updated cell as it should come out
  typedef struct {
    logic signed [H_W-1:0] height;
    logic signed [V_W-1:0] velocity;
    logic                  last;
  } cell_t;

  logic clk_i;
  logic rst_ni;

  wes_in_if  in_if ();
  wes_out_if out_if ();
  wes_cfg_if cfg_if ();

  wave_equation_stencil_step DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // columns waiting to be sent and cells waiting to be seen
  column_t pending_columns[$];
  cell_t   expected_cells[$];

  int idle_pct = 7;     // chance in a hundred that a side idles this cycle
  bit in_taken = 0;     // head column was accepted at the last rising edge
  int columns_in = 0;
  int cells_out = 0;
  int settings_used = 1;
  int mismatches = 0;

  // predictor copy of the registers, reset values
  logic [CC_W-1:0] coupling = CC_RESET;
  logic [DF_W-1:0] damping  = DF_RESET;
  logic [DT_W-1:0] tstep    = DT_RESET;

  // predictor copy of the column window
  longint          left_height = 0;   // centre of the column before the held one
  longint          win_above   = 0;
  longint          win_here    = 0;
  longint          win_below   = 0;
  longint          win_vel     = 0;
  logic [COLS_W-1:0] cols_held = COLS_NONE;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit, far above the slowest legal run
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  // scale a product with a Q.16 factor down and round to nearest, ties toward plus infinity
  function automatic longint round_q16(input longint x);
    return (x + ROUND_HALF) >>> Q16;
  endfunction

  function automatic longint saturate(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // add at the tail of the pending and expected queues
  function automatic void append_column(input column_t c);
    pending_columns.insert(pending_columns.size(), c);
  endfunction

  function automatic void append_cell(input cell_t c);
    expected_cells.insert(expected_cells.size(), c);
  endfunction

  // slide the window by one column and queue the cells that this column releases
  function automatic void advance_window(input column_t c);
    cell_t  res;
    longint lap;
    longint vn;
    longint hn;
    int     n;
    n = 0;
    // a row start drops whatever the window held
    if (c.row_start) cols_held = COLS_NONE;
    if (cols_held != COLS_NONE) begin
      if (cols_held != COLS_FULL || c.edge_row) begin
        // first cell of a row or a cell of an edge row goes out unchanged;
        // the held cell takes its edge flag from the current column
        res.height   = H_W'(win_here);
        res.velocity = V_W'(win_vel);
      end else begin
        // interior cell: right neighbour is the current column's centre
        lap = left_height + longint'(c.here) + win_above + win_below - 4 * win_here;
        vn  = win_vel + round_q16(lap * longint'(coupling));
        vn  = saturate(round_q16(vn * longint'(damping)), VEL_LIM);
        hn  = saturate(win_here + round_q16(vn * longint'(tstep)), HGT_LIM);
        res.height   = H_W'(hn);
        res.velocity = V_W'(vn);
      end
      res.last = 1'b0;
      append_cell(res);
      n++;
    end
    // the last column of a row also leaves unchanged, right behind the held one
    if (c.row_end) begin
      res.height   = c.here;
      res.velocity = c.vel;
      res.last     = 1'b0;
      append_cell(res);
      n++;
    end
    left_height = win_here;
    win_above   = c.above;
    win_here    = c.here;
    win_below   = c.below;
    win_vel     = c.vel;
    if (c.row_end) cols_held = COLS_NONE;
    else if (cols_held != COLS_FULL) cols_held = cols_held + 1'b1;
    if (n > 0) expected_cells[expected_cells.size()-1].last = 1'b1;
  endfunction

  // mostly in-range values, with plain extremes, out-of-range codes and flat water mixed in
  function automatic longint pick_value(input longint lim, input int w);
    longint top;
    top = longint'(1) << (w - 1);
    case ($urandom_range(0, 9))
      0:       return longint'($urandom_range(0, 2 * top - 1)) - top;
      1:       return $urandom_range(0, 1) ? lim : -lim;
      2:       return $urandom_range(0, 1) ? top - 1 : -top;
      3, 4, 5: return longint'($urandom_range(0, 128)) - 64;
      default: return longint'($urandom_range(0, 2 * lim)) - lim;
    endcase
  endfunction

  function automatic column_t make_column(input logic rs, input logic re, input logic er);
    column_t c;
    c.above     = H_W'(pick_value(HGT_LIM, H_W));
    c.here      = H_W'(pick_value(HGT_LIM, H_W));
    c.below     = H_W'(pick_value(HGT_LIM, H_W));
    c.vel       = V_W'(pick_value(VEL_LIM, V_W));
    c.row_start = rs;
    c.row_end   = re;
    c.edge_row  = er;
    return c;
  endfunction

  function automatic void add_column(input int a, input int h, input int b, input int v,
                                     input logic rs, input logic re, input logic er);
    column_t c;
    c.above     = H_W'(a);
    c.here      = H_W'(h);
    c.below     = H_W'(b);
    c.vel       = V_W'(v);
    c.row_start = rs;
    c.row_end   = re;
    c.edge_row  = er;
    append_column(c);
  endfunction

  // random rows: mostly whole rows, some without a row start or a row end,
  // some single columns with random flags; the batch closes its last row
  task automatic queue_rows(input int n_items);
    int   made;
    int   len;
    int   kind;
    logic er;
    made = 0;
    while (made < n_items) begin
      kind = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      er   = ($urandom_range(0, 4) == 0);
      if (kind < 10) begin
        append_column(make_column(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1))));
        made++;
      end else begin
        // kinds 10..14 lack the row start, 15..19 lack the row end
        for (int i = 0; i < len; i++) begin
          append_column(make_column((i == 0) && (kind >= 15),
                                    (i == len - 1) && !(kind >= 15 && kind < 20),
                                    er));
        end
        made += len;
      end
    end
    append_column(make_column(1'b0, 1'b1, 1'b0));
  endtask

  // register write over the configuration channel, block idle
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid     = 1'b1;
    cfg_if.reg_index = idx;
    cfg_if.wdata     = val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_COUPLING:  coupling = val[CC_W-1:0];
      REG_DAMPING:   damping  = val[DF_W-1:0];
      REG_TIME_STEP: tstep    = val[DT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic configure(input logic [CC_W-1:0] cc, input logic [DF_W-1:0] df,
                           input logic [DT_W-1:0] dt);
    write_reg(REG_COUPLING, CFG_DATA_W'(cc));
    write_reg(REG_DAMPING, CFG_DATA_W'(df));
    write_reg(REG_TIME_STEP, CFG_DATA_W'(dt));
    settings_used++;
  endtask

  // everything sent, everything seen, then room for the deepest pipeline
  task automatic wait_drained();
    while (pending_columns.size() != 0 || in_if.valid || expected_cells.size() != 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // input side: sample acceptance at the rising edge, predict from the column on the bus
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      advance_window(pending_columns[0]);
      in_taken = 1'b1;
      columns_in++;
    end
  end

  // input side: drive at the falling edge; a presented column stays until taken
  always @(negedge clk_i) begin : feed_columns
    logic hold;
    hold = in_if.valid && !in_taken;
    if (in_taken) begin
      void'(pending_columns.pop_front());
      in_taken = 1'b0;
    end
    if (!hold) begin
      if (rst_ni && pending_columns.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_if.valid         <= 1'b1;
        in_if.height_above  <= pending_columns[0].above;
        in_if.height_here   <= pending_columns[0].here;
        in_if.height_below  <= pending_columns[0].below;
        in_if.velocity_here <= pending_columns[0].vel;
        in_if.row_start     <= pending_columns[0].row_start;
        in_if.row_end       <= pending_columns[0].row_end;
        in_if.edge_row      <= pending_columns[0].edge_row;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // output side: random back pressure
  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(0, 99) >= idle_pct);
  end

  // output side: every accepted cell against the oldest expected one
  always @(posedge clk_i) begin : check_cells
    cell_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      cells_out++;
      if (expected_cells.size() == 0) begin
        $error("cell with none expected: new_height %0d new_velocity %0d",
               out_if.new_height, out_if.new_velocity);
        mismatches++;
      end else begin
        want = expected_cells.pop_front();
        if (out_if.new_height !== want.height) begin
          $error("new_height: expected %0d, actual %0d", want.height, out_if.new_height);
          mismatches++;
        end
        if (out_if.new_velocity !== want.velocity) begin
          $error("new_velocity: expected %0d, actual %0d", want.velocity, out_if.new_velocity);
          mismatches++;
        end
        if (out_if.last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, actual %0b", want.last, out_if.last_of_run);
          mismatches++;
        end
      end
    end
  end

  initial begin : run_sequence
    // known values on every input before and during reset
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.height_above  = '0;
    in_if.height_here   = '0;
    in_if.height_below  = '0;
    in_if.velocity_here = '0;
    in_if.row_start     = 1'b0;
    in_if.row_end       = 1'b0;
    in_if.edge_row      = 1'b0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.reg_index    = REG_COUPLING;
    cfg_if.wdata        = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed columns under the reset settings
    // edge row, field extremes and out-of-range codes pass through
    add_column(4095, -4096, 2048, 16383, 1'b1, 1'b0, 1'b1);
    add_column(-2048, 2048, -4096, -16384, 1'b0, 1'b0, 1'b1);
    add_column(0, 0, 0, 0, 1'b0, 1'b1, 1'b1);
    // interior row with extremes, row end gives two cells
    add_column(2048, 2048, 2048, 8192, 1'b1, 1'b0, 1'b0);
    add_column(-2048, -2048, -2048, -8192, 1'b0, 1'b0, 1'b0);
    add_column(2048, -2048, 2048, 8192, 1'b0, 1'b0, 1'b0);
    add_column(-4096, 4095, -4096, -16384, 1'b0, 1'b0, 1'b0);
    add_column(4095, -4096, 4095, 16383, 1'b0, 1'b1, 1'b0);
    // single column row
    add_column(100, -200, 300, -400, 1'b1, 1'b1, 1'b0);
    // row start in mid row drops the held column
    add_column(1, 2, 3, 4, 1'b1, 1'b0, 1'b0);
    add_column(5, 6, 7, 8, 1'b0, 1'b0, 1'b0);
    add_column(9, 10, 11, 12, 1'b0, 1'b0, 1'b0);
    add_column(13, 14, 15, 16, 1'b1, 1'b0, 1'b0);
    add_column(17, 18, 19, 20, 1'b0, 1'b1, 1'b0);
    // row with no row start flag
    add_column(-1, -1, -1, -1, 1'b0, 1'b0, 1'b0);
    add_column(-3, 5, -7, 9, 1'b0, 1'b0, 1'b0);
    add_column(11, -13, 15, -17, 1'b0, 1'b0, 1'b0);
    add_column(0, 0, 0, 0, 1'b0, 1'b1, 1'b0);
    // edge flag turns on mid row: held cell follows the current column
    add_column(500, 600, 700, 800, 1'b1, 1'b0, 1'b0);
    add_column(-500, -600, -700, -800, 1'b0, 1'b0, 1'b0);
    add_column(300, 300, 300, 300, 1'b0, 1'b0, 1'b1);
    add_column(1, 1, 1, 1, 1'b0, 1'b1, 1'b1);
    // two column row
    add_column(7, 7, 7, 7, 1'b1, 1'b0, 1'b0);
    add_column(8, 8, 8, 8, 1'b0, 1'b1, 1'b1);
    wait_drained();

    // unit coupling and damping, half step
    configure(CC_W'(65536), DF_W'(65536), DT_W'(32768));
    queue_rows(150);
    wait_drained();

    // every register at its largest code, damping above one
    configure('1, '1, '1);
    queue_rows(150);
    wait_drained();

    // everything zero: velocity dies, heights hold
    configure('0, '0, '0);
    queue_rows(150);
    wait_drained();

    // back to the reset settings with both sides streaming flat out
    idle_pct = 0;
    configure(CC_RESET, DF_RESET, DT_RESET);
    queue_rows(150);
    wait_drained();
    idle_pct = 7;

    // random settings in the useful range
    configure(CC_W'($urandom_range(0, 1 << 18)), DF_W'($urandom_range(0, 65536)),
              DT_W'($urandom));
    queue_rows(150);
    wait_drained();

    $display("%0d columns sent, %0d cells checked", columns_in, cells_out);
    $display("%0d register settings, edge rows, broken rows and saturation included",
             settings_used);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
